### rtl/core/qpfm_pkg.sv
// Package for the quarter point frequency meter: command and status codes,
// phase type, constants and the controller/datapath handshake structs.
// No dependencies.
package qpfm_pkg;

  localparam int SAMPLE_W = 12;
  localparam int WINDOW_W = 20;
  localparam int TIME_W = 24;
  localparam int FREQ_W = 34;
  localparam int CMD_W = 2;
  localparam int STATUS_W = 2;

  localparam int PERIODS_DEFAULT = 10;
  localparam int TIMEOUT_WINDOWS = 10;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 20'd16667;
  localparam logic [FREQ_W-1:0] FREQ_NUM = 34'd9986000000;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_TIMEOUT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ZERO = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WINDOW,
    PH_SYNC_FALL,
    PH_SYNC_RISE,
    PH_COUNT_FALL,
    PH_COUNT_RISE
  } phase_t;

  typedef struct packed {
    logic clear;
    logic take_sample;
    logic tick;
    logic set_thresh;
    logic restart_count;
    logic bump_cycle;
    logic finish;
    logic timed_out;
  } qpfm_cmd_t;

  typedef struct packed {
    logic window_done;
    logic timeout;
    logic le_low;
    logic gt_high;
    logic last_period;
    logic div_busy;
    logic out_pending;
  } qpfm_stat_t;

endpackage

### rtl/core/qpfm_ifs.sv
// Valid/ready channel interfaces for input items, result items and the
// window register write port. Depends on qpfm_pkg.
interface qpfm_in_if;
  logic valid;
  logic ready;
  logic [qpfm_pkg::CMD_W-1:0] command;
  logic [qpfm_pkg::SAMPLE_W-1:0] sample;
  modport source (output valid, output command, output sample, input ready);
  modport sink (input valid, input command, input sample, output ready);
endinterface

interface qpfm_out_if;
  logic valid;
  logic ready;
  logic [qpfm_pkg::FREQ_W-1:0] freq_millihertz;
  logic [qpfm_pkg::TIME_W-1:0] ten_period_us;
  logic [qpfm_pkg::SAMPLE_W-1:0] quarter_low;
  logic [qpfm_pkg::SAMPLE_W-1:0] quarter_high;
  logic [qpfm_pkg::STATUS_W-1:0] status;
  modport source (output valid, output freq_millihertz, output ten_period_us,
                  output quarter_low, output quarter_high, output status,
                  input ready);
  modport sink (input valid, input freq_millihertz, input ten_period_us,
                input quarter_low, input quarter_high, input status,
                output ready);
endinterface

interface qpfm_cfg_if;
  logic valid;
  logic ready;
  logic [qpfm_pkg::WINDOW_W-1:0] window_us;
  modport source (output valid, output window_us, input ready);
  modport sink (input valid, input window_us, output ready);
endinterface

### rtl/core/qpfm_ctrl.sv
// Measurement phase controller: decodes accepted items and issues datapath
// commands. Depends on qpfm_pkg.
module qpfm_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [qpfm_pkg::CMD_W-1:0] in_command,
  output logic in_ready,
  input  qpfm_pkg::qpfm_stat_t stat,
  output qpfm_pkg::qpfm_cmd_t cmd
);
  import qpfm_pkg::*;

  phase_t state;
  phase_t state_next;
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    in_ready = !stat.div_busy && !stat.out_pending;
    accept = in_valid && in_ready;
    cmd = '0;
    state_next = state;
    if (accept) begin
      case (in_command)
        CMD_START: begin
          cmd.clear = 1'b1;
          state_next = PH_WINDOW;
        end
        CMD_SAMPLE: begin
          case (state)
            PH_WINDOW: begin
              cmd.take_sample = 1'b1;
            end
            PH_SYNC_FALL: begin
              if (stat.le_low) begin
                state_next = PH_SYNC_RISE;
              end
            end
            PH_SYNC_RISE: begin
              if (stat.gt_high) begin
                cmd.restart_count = 1'b1;
                state_next = PH_COUNT_FALL;
              end
            end
            PH_COUNT_FALL: begin
              if (stat.le_low) begin
                state_next = PH_COUNT_RISE;
              end
            end
            PH_COUNT_RISE: begin
              if (stat.gt_high) begin
                if (stat.last_period) begin
                  cmd.finish = 1'b1;
                  state_next = PH_IDLE;
                end else begin
                  cmd.bump_cycle = 1'b1;
                  state_next = PH_COUNT_FALL;
                end
              end
            end
            default: begin
            end
          endcase
        end
        CMD_TICK: begin
          if (state != PH_IDLE) begin
            cmd.tick = 1'b1;
            case (state)
              PH_WINDOW: begin
                if (stat.window_done) begin
                  cmd.set_thresh = 1'b1;
                  state_next = PH_SYNC_FALL;
                end
              end
              PH_SYNC_FALL, PH_SYNC_RISE: begin
                if (stat.timeout) begin
                  cmd.restart_count = 1'b1;
                  state_next = PH_COUNT_FALL;
                end
              end
              PH_COUNT_FALL, PH_COUNT_RISE: begin
                if (stat.timeout) begin
                  cmd.finish = 1'b1;
                  cmd.timed_out = 1'b1;
                  state_next = PH_IDLE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/qpfm_dpath.sv
// Datapath: window register, min/max tracking, quarter points, microsecond
// and period counters, bit-serial divider and result register. Depends on
// qpfm_pkg and the channel interfaces.
module qpfm_dpath #(
  parameter int PERIODS = qpfm_pkg::PERIODS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic [qpfm_pkg::SAMPLE_W-1:0] sample,
  input  qpfm_pkg::qpfm_cmd_t cmd,
  output qpfm_pkg::qpfm_stat_t stat,
  qpfm_cfg_if.sink cfg,
  qpfm_out_if.source result
);
  import qpfm_pkg::*;

  localparam int CYC_W = $clog2(PERIODS + 1);
  localparam int ITER_W = $clog2(FREQ_W);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(FREQ_W - 1);

  logic [WINDOW_W-1:0] window_us;
  logic [WINDOW_W-1:0] eff_window;
  logic [TIME_W-1:0] limit_us;
  logic [SAMPLE_W-1:0] running_min;
  logic [SAMPLE_W-1:0] running_max;
  logic seeded;
  logic [SAMPLE_W-1:0] low_threshold;
  logic [SAMPLE_W-1:0] high_threshold;
  logic [TIME_W-1:0] elapsed_us;
  logic [TIME_W-1:0] elapsed_tick;
  logic [CYC_W-1:0] cycles_seen;
  logic [SAMPLE_W+1:0] low_sum;
  logic [SAMPLE_W+1:0] high_sum;
  logic [TIME_W-1:0] fin_time;

  logic div_busy;
  logic [ITER_W-1:0] iter;
  logic [FREQ_W-1:0] quo;
  logic [TIME_W-1:0] divisor;
  logic [TIME_W-1:0] rem;
  logic [TIME_W:0] rem_shift;
  logic [TIME_W:0] rem_diff;
  logic quo_bit;

  logic out_valid;
  logic [FREQ_W-1:0] out_freq;
  logic [TIME_W-1:0] out_time;
  logic [STATUS_W-1:0] out_status;
  logic [STATUS_W-1:0] fin_status;

  assign cfg.ready = 1'b1;
  assign eff_window = (window_us == '0) ? WINDOW_W'(1) : window_us;
  assign limit_us = TIME_W'(eff_window) * TIME_W'(TIMEOUT_WINDOWS);
  assign elapsed_tick = (elapsed_us == TIME_MAX) ? elapsed_us : elapsed_us + TIME_W'(1);
  assign low_sum = 14'(running_min) * 14'd3 + 14'(running_max);
  assign high_sum = 14'(running_min) + 14'(running_max) * 14'd3;
  assign fin_time = cmd.timed_out ? elapsed_tick : elapsed_us;
  assign fin_status = cmd.timed_out ? STAT_TIMEOUT : STAT_OK;

  assign rem_shift = {rem, quo[FREQ_W-1]};
  assign rem_diff = rem_shift - {1'b0, divisor};
  assign quo_bit = (rem_shift >= {1'b0, divisor});

  always_comb begin
    stat.window_done = (elapsed_tick >= TIME_W'(eff_window));
    stat.timeout = (elapsed_tick >= limit_us);
    stat.le_low = (sample <= low_threshold);
    stat.gt_high = (sample > high_threshold);
    stat.last_period = (cycles_seen == CYC_W'(PERIODS - 1));
    stat.div_busy = div_busy;
    stat.out_pending = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_us <= WINDOW_RESET;
      running_min <= '0;
      running_max <= '0;
      seeded <= 1'b0;
      low_threshold <= '0;
      high_threshold <= '0;
      elapsed_us <= '0;
      cycles_seen <= '0;
    end else begin
      if (cfg.valid) begin
        window_us <= cfg.window_us;
      end

      if (cmd.clear) begin
        running_min <= '0;
        running_max <= '0;
        seeded <= 1'b0;
      end else if (cmd.take_sample) begin
        seeded <= 1'b1;
        if (!seeded) begin
          running_min <= sample;
          running_max <= sample;
        end else begin
          if (sample > running_max) begin
            running_max <= sample;
          end
          if (sample < running_min) begin
            running_min <= sample;
          end
        end
      end

      if (cmd.set_thresh) begin
        low_threshold <= low_sum[SAMPLE_W+1:2];
        high_threshold <= high_sum[SAMPLE_W+1:2];
      end

      if (cmd.clear || cmd.set_thresh || cmd.restart_count) begin
        elapsed_us <= '0;
      end else if (cmd.tick) begin
        elapsed_us <= elapsed_tick;
      end

      if (cmd.clear || cmd.restart_count) begin
        cycles_seen <= '0;
      end else if (cmd.bump_cycle) begin
        cycles_seen <= cycles_seen + CYC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.finish) begin
        if (fin_time == '0) begin
          out_valid <= 1'b1;
        end else begin
          div_busy <= 1'b1;
        end
      end else if (div_busy && iter == ITER_LAST) begin
        div_busy <= 1'b0;
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_time <= fin_time;
      divisor <= fin_time;
      rem <= '0;
      iter <= '0;
      quo <= FREQ_NUM + FREQ_W'(fin_time[TIME_W-1:1]);
      if (fin_time == '0) begin
        out_freq <= FREQ_NUM;
        out_status <= STAT_ZERO;
      end else begin
        out_status <= fin_status;
      end
    end else if (div_busy) begin
      rem <= quo_bit ? rem_diff[TIME_W-1:0] : rem_shift[TIME_W-1:0];
      quo <= {quo[FREQ_W-2:0], quo_bit};
      iter <= iter + ITER_W'(1);
      if (iter == ITER_LAST) begin
        out_freq <= {quo[FREQ_W-2:0], quo_bit};
      end
    end
  end

  assign result.valid = out_valid;
  assign result.freq_millihertz = out_freq;
  assign result.ten_period_us = out_time;
  assign result.quarter_low = low_threshold;
  assign result.quarter_high = high_threshold;
  assign result.status = out_status;

endmodule

### rtl/core/quarter_point_frequency_meter_unit.sv
// Quarter point frequency meter top level: input items take one cycle each.
// At a measurement end the bit-serial divider produces the quotient one bit a cycle;
// input is held off from then until the result item is taken.
// A zero measured time skips the divider and gives its result next cycle.
// Synchronous reset clears all control state and loads window_us with 16667.
module quarter_point_frequency_meter_unit #(
  parameter int PERIODS = qpfm_pkg::PERIODS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  qpfm_in_if.sink in_item,
  qpfm_out_if.source result,
  qpfm_cfg_if.sink cfg
);
  import qpfm_pkg::*;

  qpfm_cmd_t cmd;
  qpfm_stat_t stat;

  qpfm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_item.valid),
    .in_command (in_item.command),
    .in_ready   (in_item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  qpfm_dpath #(
    .PERIODS (PERIODS)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .sample (in_item.sample),
    .cmd    (cmd),
    .stat   (stat),
    .cfg    (cfg),
    .result (result)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench for quarter_point_frequency_meter_unit: drives start, sample and tick items,
// predicts each measurement result and checks it field by field.
// Depends on qpfm_pkg and the channel interfaces in qpfm_ifs.sv.
module testbench;
  import qpfm_pkg::*;

  localparam int N_PERIODS = PERIODS_DEFAULT;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 50;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1900;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [SAMPLE_W-1:0] sample;
  } meter_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [TIME_W-1:0] period_us;
    logic [SAMPLE_W-1:0] q_low;
    logic [SAMPLE_W-1:0] q_high;
    logic [STATUS_W-1:0] status;
  } meter_reading_t;

  logic clk;
  logic rst;

  qpfm_in_if in_if();
  qpfm_out_if res_if();
  qpfm_cfg_if cfg_if();

  quarter_point_frequency_meter_unit #(
    .PERIODS(N_PERIODS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_item(in_if),
    .result(res_if),
    .cfg(cfg_if)
  );

  meter_item_t pending_items[$];
  meter_reading_t expected_readings[$];
  meter_item_t drive_item;
  meter_reading_t want;

  int send_idle_pct;
  int recv_idle_pct;
  bit out_hold;
  bit in_taken;
  int mismatches;
  int items_queued;
  event hold_request;

  logic [WINDOW_W-1:0] meter_window;
  phase_t meter_phase;
  logic [SAMPLE_W-1:0] run_min;
  logic [SAMPLE_W-1:0] run_max;
  logic [SAMPLE_W-1:0] thr_low;
  logic [SAMPLE_W-1:0] thr_high;
  logic [TIME_W-1:0] elapsed;
  logic [3:0] periods_done;
  bit seeded;

  always begin
    clk = 0;
    #1;
    clk = 1;
    #1;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
    if (mismatches < 50) begin
      $display("mismatch in %s: got %0d, expected %0d", what, got, exp);
    end
    mismatches++;
  endtask

  function automatic void close_measurement(logic [STATUS_W-1:0] st);
    longint unsigned t;
    longint unsigned num;
    meter_reading_t r;
    t = elapsed;
    num = FREQ_NUM;
    if (t == 0) begin
      r.freq = FREQ_NUM;
      if (st == STAT_OK) begin
        st = STAT_ZERO;
      end
    end else begin
      r.freq = FREQ_W'((num + t / 2) / t);
    end
    r.period_us = elapsed;
    r.q_low = thr_low;
    r.q_high = thr_high;
    r.status = st;
    expected_readings.push_back(r);
    meter_phase = PH_IDLE;
  endfunction

  function automatic void meter_step(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] s);
    int unsigned eff;
    int unsigned limit;
    eff = (meter_window == '0) ? 1 : meter_window;
    limit = eff * TIMEOUT_WINDOWS;
    if (cmd == CMD_START) begin
      meter_phase = PH_WINDOW;
      run_min = '0;
      run_max = '0;
      elapsed = '0;
      periods_done = '0;
      seeded = 0;
      return;
    end
    if (cmd == CMD_NONE || meter_phase == PH_IDLE) begin
      return;
    end
    if (cmd == CMD_TICK) begin
      if (elapsed != TIME_MAX) begin
        elapsed++;
      end
      if (meter_phase == PH_WINDOW) begin
        if (elapsed >= eff) begin
          thr_low = SAMPLE_W'((3 * run_min + run_max) / 4);
          thr_high = SAMPLE_W'((run_min + 3 * run_max) / 4);
          elapsed = '0;
          meter_phase = PH_SYNC_FALL;
        end
      end else if (elapsed >= limit) begin
        if (meter_phase == PH_SYNC_FALL || meter_phase == PH_SYNC_RISE) begin
          elapsed = '0;
          periods_done = '0;
          meter_phase = PH_COUNT_FALL;
        end else begin
          close_measurement(STAT_TIMEOUT);
        end
      end
      return;
    end
    case (meter_phase)
      PH_WINDOW: begin
        if (!seeded) begin
          run_min = s;
          run_max = s;
          seeded = 1;
        end else begin
          if (s > run_max) run_max = s;
          if (s < run_min) run_min = s;
        end
      end
      PH_SYNC_FALL: begin
        if (s <= thr_low) meter_phase = PH_SYNC_RISE;
      end
      PH_SYNC_RISE: begin
        if (s > thr_high) begin
          elapsed = '0;
          periods_done = '0;
          meter_phase = PH_COUNT_FALL;
        end
      end
      PH_COUNT_FALL: begin
        if (s <= thr_low) meter_phase = PH_COUNT_RISE;
      end
      PH_COUNT_RISE: begin
        if (s > thr_high) begin
          periods_done = periods_done + 1'b1;
          if (periods_done >= N_PERIODS) begin
            close_measurement(STAT_OK);
          end else begin
            meter_phase = PH_COUNT_FALL;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    in_taken = !rst && in_if.valid && in_if.ready;
    if (in_taken) begin
      meter_step(in_if.command, in_if.sample);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected result freq_millihertz", res_if.freq_millihertz, 0);
      end else begin
        want = expected_readings.pop_front();
        if (res_if.freq_millihertz !== want.freq)
          report_mismatch("freq_millihertz", res_if.freq_millihertz, want.freq);
        if (res_if.ten_period_us !== want.period_us)
          report_mismatch("ten_period_us", res_if.ten_period_us, want.period_us);
        if (res_if.quarter_low !== want.q_low)
          report_mismatch("quarter_low", res_if.quarter_low, want.q_low);
        if (res_if.quarter_high !== want.q_high)
          report_mismatch("quarter_high", res_if.quarter_high, want.q_high);
        if (res_if.status !== want.status)
          report_mismatch("status", res_if.status, want.status);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_item = pending_items.pop_front();
        in_if.valid <= 1'b1;
        in_if.command <= drive_item.cmd;
        in_if.sample <= drive_item.sample;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    res_if.ready <= !rst && !out_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    forever begin
      @(hold_request);
      out_hold = 1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_hold = 0;
    end
  end

  task automatic queue_item(logic [CMD_W-1:0] cmd, int unsigned s);
    meter_item_t it;
    it.cmd = cmd;
    it.sample = SAMPLE_W'(s);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_ticks(int unsigned n);
    repeat (n) queue_item(CMD_TICK, $urandom_range(4095));
  endtask

  task automatic queue_noise(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 4) queue_item(CMD_START, $urandom_range(4095));
      else if (r < 20) queue_item(CMD_NONE, $urandom_range(4095));
      else if (r < 60) queue_item(CMD_SAMPLE, $urandom_range(4095));
      else queue_item(CMD_TICK, $urandom_range(4095));
    end
  endtask

  task automatic queue_measurement(int unsigned w);
    int unsigned lo, hi, q1, q3, top, tick_max, shape;
    bit empty_win;
    bit rise_ok;
    shape = $urandom_range(9);
    if (shape == 0) begin
      lo = 0;
      hi = 4095;
    end else if (shape == 1) begin
      lo = $urandom_range(4095);
      hi = lo;
    end else begin
      lo = $urandom_range(3000);
      hi = $urandom_range(4095, lo + 4);
    end
    empty_win = ($urandom_range(9) == 0);
    if (empty_win) begin
      lo = 0;
      hi = 0;
    end
    q1 = (3 * lo + hi) / 4;
    q3 = (lo + 3 * hi) / 4;
    rise_ok = (q3 < 4095);
    top = (q3 < hi) ? hi : 4095;
    queue_item(CMD_START, $urandom_range(4095));
    if (!empty_win) begin
      if ($urandom_range(1)) begin
        queue_item(CMD_SAMPLE, lo);
        queue_item(CMD_SAMPLE, hi);
      end else begin
        queue_item(CMD_SAMPLE, hi);
        queue_item(CMD_SAMPLE, lo);
      end
      repeat ($urandom_range(3)) queue_item(CMD_SAMPLE, $urandom_range(hi, lo));
    end
    queue_ticks(w - 1);
    if (!empty_win && $urandom_range(1)) queue_item(CMD_SAMPLE, $urandom_range(hi, lo));
    queue_ticks(1);
    if (!rise_ok || $urandom_range(9) == 0) begin
      if (q3 > q1) queue_item(CMD_SAMPLE, $urandom_range(q3, q1 + 1));
      queue_ticks(TIMEOUT_WINDOWS * w);
    end else begin
      queue_ticks($urandom_range(2));
      queue_item(CMD_SAMPLE, $urandom_range(q1, lo));
      queue_ticks($urandom_range(2));
      queue_item(CMD_SAMPLE, $urandom_range(top, q3 + 1));
    end
    tick_max = ($urandom_range(5) == 0) ? 0 : $urandom_range(3, 1);
    for (int p = 0; p < N_PERIODS; p++) begin
      queue_ticks($urandom_range(tick_max));
      queue_item(CMD_SAMPLE, $urandom_range(q1, lo));
      if ($urandom_range(19) == 0) queue_noise(1);
      queue_ticks($urandom_range(tick_max));
      if (p == N_PERIODS / 2 && $urandom_range(9) == 0) queue_ticks(TIMEOUT_WINDOWS * w);
      if (rise_ok) queue_item(CMD_SAMPLE, $urandom_range(top, q3 + 1));
    end
    if (!rise_ok) queue_ticks(TIMEOUT_WINDOWS * w);
  endtask

  task automatic write_window(logic [WINDOW_W-1:0] w);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.window_us <= w;
    do @(posedge clk); while (!cfg_if.ready);
    meter_window = w;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_if.valid) @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned small_windows[7];
    int directed_items;
    int rand_items;
    int phase_no;
    logic [WINDOW_W-1:0] w;
    int unsigned eff;

    small_windows = '{1, 2, 3, 5, 8, 13, 0};
    rst = 1;
    in_if.valid = 0;
    in_if.command = CMD_START;
    in_if.sample = '0;
    res_if.ready = 0;
    cfg_if.valid = 0;
    cfg_if.window_us = '0;
    out_hold = 0;
    mismatches = 0;
    items_queued = 0;
    send_idle_pct = 14;
    recv_idle_pct = 51;
    meter_window = WINDOW_RESET;
    meter_phase = PH_IDLE;
    run_min = '0;
    run_max = '0;
    thr_low = '0;
    thr_high = '0;
    elapsed = '0;
    periods_done = '0;
    seeded = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Idle block ignores samples, ticks and the unused command.
    queue_item(CMD_TICK, 0);
    queue_item(CMD_SAMPLE, 4095);
    queue_item(CMD_NONE, 0);
    drain();

    // Zero window acts as one tick; restart while busy; empty window; zero time.
    write_window('0);
    queue_item(CMD_START, 4095);
    queue_item(CMD_SAMPLE, 2048);
    queue_item(CMD_START, 0);
    queue_item(CMD_TICK, 4095);
    queue_item(CMD_SAMPLE, 0);
    queue_item(CMD_SAMPLE, 4095);
    repeat (N_PERIODS) begin
      queue_item(CMD_SAMPLE, 0);
      queue_item(CMD_SAMPLE, $urandom_range(4095, 1));
    end
    drain();
    directed_items = items_queued;

    phase_no = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS && phase_no < 400) begin
      if (rand_items < RANDOM_ITEMS / 3) begin
        send_idle_pct = 14;
        recv_idle_pct = 51;
      end else if (rand_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase_no % 9 == 8) begin
        w = (phase_no % 2) ? 20'd1000000 : 20'hFFFFF;
        write_window(w);
        queue_item(CMD_START, $urandom_range(4095));
        repeat (10) queue_item(CMD_SAMPLE, $urandom_range(4095));
        queue_ticks(30);
        queue_noise(10);
      end else begin
        w = WINDOW_W'(small_windows[phase_no % 7]);
        eff = (w == '0) ? 1 : w;
        write_window(w);
        if (phase_no == 2) -> hold_request;
        repeat ($urandom_range(4, 2)) queue_measurement(eff);
        if ($urandom_range(9) < 3) queue_noise(20);
      end
      drain();
      rand_items = items_queued - directed_items;
      phase_no++;
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

### sim.f
rtl/core/qpfm_pkg.sv
rtl/core/qpfm_ifs.sv
rtl/core/qpfm_ctrl.sv
rtl/core/qpfm_dpath.sv
rtl/core/quarter_point_frequency_meter_unit.sv
tb/sv/testbench.sv
